// ===== sv/knap_pkg.sv =====
package knap_pkg;

  localparam int MAX_CAPACITY = 1024;
  localparam int SUM_WIDTH    = 24;

  localparam int CFG_W   = 11;
  localparam int VAL_W   = 16;
  localparam int WGT_W   = 16;
  localparam int OUT_W   = 24;
  localparam int CAP_W   = $clog2(MAX_CAPACITY + 1);
  localparam int DEPTH   = MAX_CAPACITY + 1;
  localparam int SUM_EXT_W = ((SUM_WIDTH > VAL_W) ? SUM_WIDTH : VAL_W) + 1;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic walk_rd;
    logic rd_cap;
    logic load_out;
    logic clr_wr;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fits;
    logic walk_end;
    logic clr_end;
    logic last;
    logic out_busy;
  } sts_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_WALK   = 7'b0000010,
    ST_DRAIN  = 7'b0000100,
    ST_RDCAP  = 7'b0001000,
    ST_RESULT = 7'b0010000,
    ST_CLEAR  = 7'b0100000,
    ST_SPARE  = 7'b1000000
  } state_e;

endpackage

// ===== sv/knapsack_01_table_engine.sv =====
// 0/1 knapsack over a row of best totals, one entry per capacity, one table port pair.
// Item: accepted in idle, then a walk from cap down to weight, then a drain state for the
// last write; an item that does not fit goes straight to the drain. Last item then reads
// the answer at entry cap, then a beat is offered once the output register is free.
// The row is cleared by a pass over all MAX_CAPACITY+1 (1025) entries after reset and
// after each answer; no item is taken during the pass. Async active-low reset, cap = 1024.
module knapsack_01_table_engine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [knap_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [knap_pkg::VAL_W-1:0] item_value_i,
  input  logic [knap_pkg::WGT_W-1:0] item_weight_i,
  input  logic                       last_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [knap_pkg::OUT_W-1:0] best_value_o
);
  import knap_pkg::*;

  cmd_t cmd;
  sts_t sts;

  knap_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  knap_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .item_value_i  (item_value_i),
    .item_weight_i (item_weight_i),
    .last_item_i   (last_item_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .best_value_o  (best_value_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

// ===== sv/knap_ctrl.sv =====
module knap_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  knap_pkg::sts_t sts_i,
  output knap_pkg::cmd_t cmd_o
);
  import knap_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        // an item heavier than the capacity leaves the row alone
        if (sts_i.fits) begin
          cmd_o.walk_rd = 1'b1;
        end
        if (!sts_i.fits || sts_i.walk_end) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // final write of the walk lands here
        state_d = sts_i.last ? ST_RDCAP : ST_IDLE;
      end
      ST_RDCAP: begin
        cmd_o.rd_cap = 1'b1;
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_end) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// ===== sv/knap_dp.sv =====
module knap_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [knap_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic [knap_pkg::VAL_W-1:0]    item_value_i,
  input  logic [knap_pkg::WGT_W-1:0]    item_weight_i,
  input  logic                          last_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [knap_pkg::OUT_W-1:0]    best_value_o,
  input  knap_pkg::cmd_t                cmd_i,
  output knap_pkg::sts_t                sts_o
);
  import knap_pkg::*;

  localparam logic [SUM_WIDTH-1:0] SumMax = {SUM_WIDTH{1'b1}};

  logic [CFG_W-1:0]     cap_q;
  logic [CAP_W-1:0]     cap_use;
  logic [VAL_W-1:0]     value_q;
  logic [WGT_W-1:0]     weight_q;
  logic                 last_q;
  logic [CAP_W-1:0]     addr_q, addr_d;
  logic [CAP_W-1:0]     wgt_lo;
  logic [CAP_W-1:0]     rd_addr;
  logic [CAP_W-1:0]     take_addr;
  logic                 rd_en;

  logic [SUM_WIDTH-1:0] mem [DEPTH];
  logic [SUM_WIDTH-1:0] keep_q, take_q;
  logic                 wr_pend_q;
  logic [CAP_W-1:0]     wr_addr_q;

  logic [SUM_EXT_W-1:0] sum_ext;
  logic [SUM_WIDTH-1:0] take_sat;
  logic [SUM_WIDTH-1:0] best;
  logic                 mem_we;
  logic [CAP_W-1:0]     mem_wa;
  logic [SUM_WIDTH-1:0] mem_wd;

  logic                 out_valid_q;
  logic [OUT_W-1:0]     out_data_q;

  assign cap_use = (32'(cap_q) > MAX_CAPACITY) ? CAP_W'(MAX_CAPACITY) : CAP_W'(cap_q);
  assign wgt_lo  = weight_q[CAP_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CFG_W'(MAX_CAPACITY);
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      value_q  <= item_value_i;
      weight_q <= item_weight_i;
      last_q   <= last_item_i;
    end
  end

  // walk / clear address, counts downward
  always_comb begin
    addr_d = addr_q;
    if (cmd_i.load_item) begin
      addr_d = cap_use;
    end else if (cmd_i.load_out) begin
      addr_d = CAP_W'(MAX_CAPACITY);
    end else if (cmd_i.walk_rd || cmd_i.clr_wr) begin
      addr_d = addr_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= CAP_W'(MAX_CAPACITY);
      wr_pend_q <= 1'b0;
    end else begin
      addr_q    <= addr_d;
      wr_pend_q <= cmd_i.walk_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_rd) begin
      wr_addr_q <= addr_q;
    end
  end

  // writes always trail the reads at higher addresses, so no forwarding
  assign rd_en     = cmd_i.walk_rd || cmd_i.rd_cap;
  assign rd_addr   = cmd_i.rd_cap ? cap_use : addr_q;
  assign take_addr = addr_q - wgt_lo;

  assign sum_ext  = SUM_EXT_W'(take_q) + SUM_EXT_W'(value_q);
  assign take_sat = (sum_ext > SUM_EXT_W'(SumMax)) ? SumMax : SUM_WIDTH'(sum_ext);
  assign best     = (take_sat > keep_q) ? take_sat : keep_q;

  assign mem_we = wr_pend_q || cmd_i.clr_wr;
  assign mem_wa = cmd_i.clr_wr ? addr_q : wr_addr_q;
  assign mem_wd = cmd_i.clr_wr ? '0 : best;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      keep_q <= mem[rd_addr];
      take_q <= mem[take_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= OUT_W'(keep_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign best_value_o = out_data_q;

  assign sts_o.fits     = (32'(weight_q) <= 32'(cap_use));
  assign sts_o.walk_end = (addr_q == wgt_lo);
  assign sts_o.clr_end  = (addr_q == '0);
  assign sts_o.last     = last_q;
  assign sts_o.out_busy = out_valid_q && out_stall_i;

endmodule
